/* rtl/md5_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// md5_pkg
// Shared types, constants and round tables for the MD5 digest engine.
// ============================================================================
package md5_pkg;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LAST_POS = 6'h3F;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } md5_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } md5_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } md5_state_t;

    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_OUT
    } md5_ret_t;

    typedef enum logic [1:0] {
        WSEL_DATA,
        WSEL_MARK,
        WSEL_ZERO,
        WSEL_LEN
    } md5_wsel_t;

    typedef struct packed {
        logic       wr_en;
        md5_wsel_t  wr_sel;
        logic [5:0] wr_addr;
        logic       len_inc;
        logic       load;
        logic       round_en;
        logic [5:0] round;
        logic [3:0] rd_addr;
        logic       fold;
        logic       clear;
        logic [1:0] word_sel;
    } md5_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
    } md5_stat_t;

    function automatic logic [3:0] md5_msg_index(input logic [5:0] r);
        logic [8:0] t;
        case (r[5:4])
            2'd0:    t = {3'd0, r};
            2'd1:    t = 9'(r) * 9'd5 + 9'd1;
            2'd2:    t = 9'(r) * 9'd3 + 9'd5;
            default: t = 9'(r) * 9'd7;
        endcase
        return t[3:0];
    endfunction

    function automatic logic [4:0] md5_shift(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0:    s = 5'd7;
            4'd1:    s = 5'd12;
            4'd2:    s = 5'd17;
            4'd3:    s = 5'd22;
            4'd4:    s = 5'd5;
            4'd5:    s = 5'd9;
            4'd6:    s = 5'd14;
            4'd7:    s = 5'd20;
            4'd8:    s = 5'd4;
            4'd9:    s = 5'd11;
            4'd10:   s = 5'd16;
            4'd11:   s = 5'd23;
            4'd12:   s = 5'd6;
            4'd13:   s = 5'd10;
            4'd14:   s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] md5_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:    k = 32'hd76aa478;
            6'd1:    k = 32'he8c7b756;
            6'd2:    k = 32'h242070db;
            6'd3:    k = 32'hc1bdceee;
            6'd4:    k = 32'hf57c0faf;
            6'd5:    k = 32'h4787c62a;
            6'd6:    k = 32'ha8304613;
            6'd7:    k = 32'hfd469501;
            6'd8:    k = 32'h698098d8;
            6'd9:    k = 32'h8b44f7af;
            6'd10:   k = 32'hffff5bb1;
            6'd11:   k = 32'h895cd7be;
            6'd12:   k = 32'h6b901122;
            6'd13:   k = 32'hfd987193;
            6'd14:   k = 32'ha679438e;
            6'd15:   k = 32'h49b40821;
            6'd16:   k = 32'hf61e2562;
            6'd17:   k = 32'hc040b340;
            6'd18:   k = 32'h265e5a51;
            6'd19:   k = 32'he9b6c7aa;
            6'd20:   k = 32'hd62f105d;
            6'd21:   k = 32'h02441453;
            6'd22:   k = 32'hd8a1e681;
            6'd23:   k = 32'he7d3fbc8;
            6'd24:   k = 32'h21e1cde6;
            6'd25:   k = 32'hc33707d6;
            6'd26:   k = 32'hf4d50d87;
            6'd27:   k = 32'h455a14ed;
            6'd28:   k = 32'ha9e3e905;
            6'd29:   k = 32'hfcefa3f8;
            6'd30:   k = 32'h676f02d9;
            6'd31:   k = 32'h8d2a4c8a;
            6'd32:   k = 32'hfffa3942;
            6'd33:   k = 32'h8771f681;
            6'd34:   k = 32'h6d9d6122;
            6'd35:   k = 32'hfde5380c;
            6'd36:   k = 32'ha4beea44;
            6'd37:   k = 32'h4bdecfa9;
            6'd38:   k = 32'hf6bb4b60;
            6'd39:   k = 32'hbebfbc70;
            6'd40:   k = 32'h289b7ec6;
            6'd41:   k = 32'heaa127fa;
            6'd42:   k = 32'hd4ef3085;
            6'd43:   k = 32'h04881d05;
            6'd44:   k = 32'hd9d4d039;
            6'd45:   k = 32'he6db99e5;
            6'd46:   k = 32'h1fa27cf8;
            6'd47:   k = 32'hc4ac5665;
            6'd48:   k = 32'hf4292244;
            6'd49:   k = 32'h432aff97;
            6'd50:   k = 32'hab9423a7;
            6'd51:   k = 32'hfc93a039;
            6'd52:   k = 32'h655b59c3;
            6'd53:   k = 32'h8f0ccc92;
            6'd54:   k = 32'hffeff47d;
            6'd55:   k = 32'h85845dd1;
            6'd56:   k = 32'h6fa87e4f;
            6'd57:   k = 32'hfe2ce6e0;
            6'd58:   k = 32'ha3014314;
            6'd59:   k = 32'h4e0811a1;
            6'd60:   k = 32'hf7537e82;
            6'd61:   k = 32'hbd3af235;
            6'd62:   k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

endpackage

/* rtl/md5_message_digest_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// md5_message_digest_top
// MD5 digest engine: byte-wide absorb, padding and four-word digest readout.
// ============================================================================
// An absorb transfer writes one byte into the block; the 64th byte of a block
// adds a compression (load, 64 rounds at one round per cycle through the single
// round unit, and the chaining fold), during which no byte is taken. A finish
// transfer writes the padding one byte per cycle up to the end of the block,
// compresses once or twice and then offers the four digest words, index 0
// first, each on its own result transfer. No new item is taken until the last
// digest word has been transferred; the engine then starts over from the
// initial chaining values.
module md5_message_digest_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  md5_pkg::md5_in_t  item,
    output logic              result_valid,
    input  logic              result_ready,
    output md5_pkg::md5_out_t result
);
    import md5_pkg::*;

    md5_cmd_t    cmd;
    md5_stat_t   stat;
    logic [1:0]  word_index;
    logic [31:0] digest_word;

    md5_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (item.operation),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .word_index   (word_index),
        .cmd          (cmd),
        .stat         (stat)
    );

    md5_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (item.data_byte),
        .cmd         (cmd),
        .stat        (stat),
        .digest_word (digest_word)
    );

    assign result.digest_word = digest_word;
    assign result.word_index  = word_index;
    assign result.last_word   = (word_index == 2'd3);

    assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
        else $error("input accepted while digest readout is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && result.last_word) |=> item_ready)
        else $error("engine not idle after final digest word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !result.last_word) |=>
        (result_valid && result.word_index == $past(result.word_index) + 2'd1))
        else $error("digest words not delivered in order");

    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.operation == OP_FINISH) |=> !item_ready)
        else $error("finish did not start padding");

endmodule

/* rtl/md5_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// md5_ctrl
// Sequencer: byte absorb, padding, compression rounds and digest readout.
// ============================================================================
module md5_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic              operation,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [1:0]        word_index,
    output md5_pkg::md5_cmd_t cmd,
    input  md5_pkg::md5_stat_t stat
);
    import md5_pkg::*;

    md5_state_t state_reg, state_next;
    md5_ret_t   ret_reg, ret_next;
    logic [5:0] round_reg, round_next;
    logic [5:0] pad_reg, pad_next;
    logic       len_ok_reg, len_ok_next;
    logic [1:0] word_reg, word_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ret_reg    <= RET_IDLE;
            round_reg  <= '0;
            pad_reg    <= '0;
            len_ok_reg <= 1'b0;
            word_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            round_reg  <= round_next;
            pad_reg    <= pad_next;
            len_ok_reg <= len_ok_next;
            word_reg   <= word_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        round_next  = round_reg;
        pad_next    = pad_reg;
        len_ok_next = len_ok_reg;
        word_next   = word_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (operation == OP_FINISH)
                    begin
                        if (stat.pos == LAST_POS)
                        begin
                            state_next = ST_LOAD;
                            ret_next   = RET_PAD;
                        end
                        else
                        begin
                            state_next  = ST_PAD;
                            pad_next    = stat.pos + 6'd1;
                            len_ok_next = (stat.pos < LEN_POS);
                        end
                    end
                    else if (stat.pos == LAST_POS)
                    begin
                        state_next = ST_LOAD;
                        ret_next   = RET_IDLE;
                    end
                end
            end
            ST_PAD:
            begin
                pad_next = pad_reg + 6'd1;
                if (pad_reg == LAST_POS)
                begin
                    state_next = ST_LOAD;
                    ret_next   = len_ok_reg ? RET_OUT : RET_PAD;
                end
            end
            ST_LOAD:
            begin
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_POS)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                case (ret_reg)
                    RET_PAD:
                    begin
                        state_next  = ST_PAD;
                        pad_next    = '0;
                        len_ok_next = 1'b1;
                    end
                    RET_OUT:
                    begin
                        state_next = ST_OUT;
                        word_next  = '0;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_OUT:
            begin
                if (result_ready)
                begin
                    word_next = word_reg + 2'd1;
                    if (word_reg == 2'd3)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.wr_sel   = WSEL_ZERO;
        item_ready   = 1'b0;
        result_valid = 1'b0;
        word_index   = word_reg;
        cmd.word_sel = word_reg;
        cmd.round    = round_reg;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.wr_en   = item_valid;
                cmd.wr_addr = stat.pos;
                cmd.wr_sel  = (operation == OP_FINISH) ? WSEL_MARK : WSEL_DATA;
                cmd.len_inc = item_valid && (operation == OP_ABSORB);
            end
            ST_PAD:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = pad_reg;
                cmd.wr_sel  = (len_ok_reg && (pad_reg inside {[LEN_POS:LAST_POS]}))
                              ? WSEL_LEN : WSEL_ZERO;
            end
            ST_LOAD:
            begin
                cmd.load    = 1'b1;
                cmd.rd_addr = md5_msg_index(6'd0);
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                cmd.rd_addr  = md5_msg_index(round_reg + 6'd1);
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
            end
            ST_OUT:
            begin
                result_valid = 1'b1;
                cmd.clear    = result_ready && (word_reg == 2'd3);
            end
            default: ;
        endcase
    end

endmodule

/* rtl/md5_datapath.sv */
`timescale 1ns / 1ps
// ============================================================================
// md5_datapath
// Block buffer, bit count, round registers and chaining words.
// ============================================================================
module md5_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         data_byte,
    input  md5_pkg::md5_cmd_t  cmd,
    output md5_pkg::md5_stat_t stat,
    output logic [31:0]        digest_word
);
    import md5_pkg::*;

    logic [7:0]  block_mem [4][16];
    logic [7:0]  rd_q [4];
    logic [63:0] bit_len_reg;
    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [7:0]  wr_byte;
    logic [31:0] msg_word;
    logic [31:0] f_val;
    logic [31:0] sum_val;
    logic [63:0] rot_wide;
    logic [31:0] b_new;

    always_comb
    begin
        case (cmd.wr_sel)
            WSEL_DATA: wr_byte = data_byte;
            WSEL_MARK: wr_byte = PAD_MARK;
            WSEL_LEN:  wr_byte = bit_len_reg[{cmd.wr_addr[2:0], 3'b000} +: 8];
            default:   wr_byte = 8'h00;
        endcase
    end

    // byte lanes of the 16-word block, one read address for all lanes
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            block_mem[cmd.wr_addr[1:0]][cmd.wr_addr[5:2]] <= wr_byte;
        for (int l = 0; l < 4; l++)
            rd_q[l] <= block_mem[l][cmd.rd_addr];
    end

    assign msg_word = {rd_q[3], rd_q[2], rd_q[1], rd_q[0]};

    always_comb
    begin
        case (cmd.round[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
    end

    assign sum_val  = a_reg + f_val + md5_k(cmd.round) + msg_word;
    assign rot_wide = {sum_val, sum_val} << md5_shift(cmd.round);
    assign b_new    = b_reg + rot_wide[63:32];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        else if (cmd.round_en)
        begin
            a_reg <= d_reg;
            b_reg <= b_new;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_len_reg  <= '0;
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
        end
        else if (cmd.clear)
        begin
            bit_len_reg  <= '0;
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
        end
        else
        begin
            if (cmd.len_inc)
                bit_len_reg <= bit_len_reg + 64'd8;
            if (cmd.fold)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end
        end
    end

    assign stat.pos    = bit_len_reg[8:3];
    assign digest_word = chain_reg[cmd.word_sel];

endmodule

/* test/tb_md5_message_digest_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_md5_message_digest_top
// Self-checking bench for the MD5 digest engine.
// ============================================================================
// Messages are fed byte by byte as absorb transfers and closed with a finish
// transfer. A behavioral MD5 inside the bench folds each accepted transfer and
// queues the four digest words that a finish must produce. The receiver side
// compares every result transfer field by field against the oldest queued
// word. Directed messages (empty, short strings, byte extremes, back-to-back
// finishes) come first, then random messages whose lengths cluster on the
// padding and block boundaries. Both handshakes see random gaps and stalls.
// ============================================================================
module tb_md5_message_digest_top;

    import md5_pkg::*;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     item_valid   = 1'b0;
    logic     item_ready;
    md5_in_t  item         = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    md5_out_t result;

    md5_message_digest_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    logic [31:0] sine_table [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    int rotate_table [0:15] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    logic [31:0] hash_state [4];
    logic [7:0]  msg_block  [64];
    logic [63:0] msg_bits;
    md5_out_t    expected_words [$];

    int  mismatches   = 0;
    int  items_sent   = 0;
    bit  burst_mode   = 1'b0;
    int  stall_left   = 0;

    function automatic void restart_digest();
        hash_state[0] = INIT_A;
        hash_state[1] = INIT_B;
        hash_state[2] = INIT_C;
        hash_state[3] = INIT_D;
        msg_bits      = '0;
    endfunction

    function automatic logic [31:0] block_word(input int idx);
        int p;
        p = (idx & 15) * 4;
        return {msg_block[p + 3], msg_block[p + 2], msg_block[p + 1], msg_block[p]};
    endfunction

    function automatic void compress_block();
        logic [31:0] a, b, c, d, f, mixed;
        int          g, s;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        for (int r = 0; r < 64; r++)
        begin
            case (r / 16)
                0:       begin f = (b & c) | (~b & d); g = r;         end
                1:       begin f = (b & d) | (c & ~d); g = 5 * r + 1; end
                2:       begin f = b ^ c ^ d;          g = 3 * r + 5; end
                default: begin f = c ^ (b | ~d);       g = 7 * r;     end
            endcase
            mixed = a + f + sine_table[r] + block_word(g);
            s     = rotate_table[((r / 16) * 4) + (r % 4)];
            a     = d;
            d     = c;
            c     = b;
            b     = b + ((mixed << s) | (mixed >> (32 - s)));
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
    endfunction

    // Fold one accepted transfer; a finish queues the four digest words.
    function automatic void fold_into_digest(input md5_in_t t);
        int       p;
        md5_out_t w;
        p = int'(msg_bits[8:3]);
        if (t.operation == OP_ABSORB)
        begin
            msg_block[p] = t.data_byte;
            msg_bits += 64'd8;
            if (p == 63)
                compress_block();
        end
        else
        begin
            msg_block[p] = PAD_MARK;
            p++;
            if (p > 56)
            begin
                while (p < 64)
                begin
                    msg_block[p] = 8'h00;
                    p++;
                end
                compress_block();
                p = 0;
            end
            while (p < 56)
            begin
                msg_block[p] = 8'h00;
                p++;
            end
            for (int i = 0; i < 8; i++)
                msg_block[56 + i] = msg_bits[8 * i +: 8];
            compress_block();
            for (int k = 0; k < 4; k++)
            begin
                w.digest_word = hash_state[k];
                w.word_index  = k[1:0];
                w.last_word   = (k == 3);
                expected_words.push_back(w);
            end
            restart_digest();
        end
    endfunction

    function automatic int pick_gap();
        if (burst_mode)
            return 0;
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 2);
        return $urandom_range(3, 24);
    endfunction

    // Receiver: random back-pressure and result checking.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result transfer, actual %h", $time, result);
                mismatches++;
            end
            else
            begin
                md5_out_t w;
                w = expected_words.pop_front();
                if (result.digest_word !== w.digest_word)
                begin
                    $display("%0t: digest_word expected %h actual %h",
                             $time, w.digest_word, result.digest_word);
                    mismatches++;
                end
                if (result.word_index !== w.word_index)
                begin
                    $display("%0t: word_index expected %0d actual %0d",
                             $time, w.word_index, result.word_index);
                    mismatches++;
                end
                if (result.last_word !== w.last_word)
                begin
                    $display("%0t: last_word expected %0b actual %0b",
                             $time, w.last_word, result.last_word);
                    mismatches++;
                end
            end
        end
        if (stall_left != 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    task automatic send_item(input logic op, input logic [7:0] data);
        int      gap;
        md5_in_t t;
        gap = pick_gap();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        t.operation = op;
        t.data_byte = data;
        item_valid <= 1'b1;
        item       <= t;
        do
            @(posedge clk);
        while (!item_ready);
        fold_into_digest(t);
        items_sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
        send_item(OP_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_message();
        send_item(OP_FINISH, 8'hFF);
    endtask

    task automatic test_short_strings();
        send_item(OP_ABSORB, 8'h61);
        send_item(OP_ABSORB, 8'h62);
        send_item(OP_ABSORB, 8'h63);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_ABSORB, 8'h61);
        send_item(OP_FINISH, 8'h5A);
    endtask

    task automatic test_byte_extremes();
        send_item(OP_ABSORB, 8'h00);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_ABSORB, 8'hFF);
        send_item(OP_FINISH, 8'hFF);
    endtask

    task automatic test_back_to_back_finish();
        burst_mode = 1'b1;
        send_item(OP_FINISH, 8'hA5);
        send_item(OP_FINISH, 8'h5A);
        burst_mode = 1'b0;
    endtask

    // Sender holds off until all digest words are out, then resumes.
    task automatic test_drain_pause();
        send_message(5);
        item_valid <= 1'b0;
        wait_drained();
        @(posedge clk);
        send_message(3);
    endtask

    // Lengths cluster around the one/two-compression padding split and
    // the block edge.
    task automatic test_random_messages();
        int len;
        while (items_sent < 100)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(0, 12);
                6:                len = $urandom_range(53, 58);
                7:                len = $urandom_range(62, 66);
                8:                len = $urandom_range(118, 122);
                default:          len = $urandom_range(13, 52);
            endcase
            burst_mode = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0)
            begin
                item_valid <= 1'b0;
                wait_drained();
                @(posedge clk);
            end
            send_message(len);
        end
        burst_mode = 1'b0;
    endtask

    initial
    begin
        restart_digest();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_message();
        test_short_strings();
        test_byte_extremes();
        test_back_to_back_finish();
        test_drain_pause();
        test_random_messages();

        item_valid <= 1'b0;
        wait_drained();
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("md5_message_digest_top verification clean");
        else
            $display("md5_message_digest_top verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("md5_message_digest_top verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/md5_pkg.sv
rtl/md5_ctrl.sv
rtl/md5_datapath.sv
rtl/md5_message_digest_top.sv
test/tb_md5_message_digest_top.sv
